// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/ttac_pkg.sv =====
`timescale 1ns / 1ps
package ttac_pkg;
	localparam int TableDepth = 128;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = IdxW + 1;
	localparam int TileEdge = 2560;
	localparam int CoordW = 24;
	// Wide enough for doubled sums of coordinates and sizes.
	localparam int WideW = 28;

	typedef enum logic [1:0] {
		CMD_PLACE   = 2'd0,
		CMD_REMOVE  = 2'd1,
		CMD_RESOLVE = 2'd2,
		CMD_PROBE   = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_PLACED   = 3'd0,
		ST_OCCUPIED = 3'd1,
		ST_FULL     = 3'd2,
		ST_REMOVED  = 3'd3,
		ST_NOHIT    = 3'd4,
		ST_DONE     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'd0,
		S_SCAN  = 3'd1,
		S_SHIFT = 3'd2,
		S_DONE  = 3'd3,
		S_OUT   = 3'd4
	} state_t;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	function automatic logic signed [CoordW-1:0] sat24(input logic signed [WideW-1:0] v);
		logic signed [WideW-1:0] hi;
		logic signed [WideW-1:0] lo;
		hi = WideW'(signed'(24'sh7FFFFF));
		lo = WideW'(signed'(24'sh800000));
		if (v > hi) return 24'sh7FFFFF;
		else if (v < lo) return 24'sh800000;
		else return v[CoordW-1:0];
	endfunction
endpackage

// ===== rtl/tile_table_aabb_collision_top.sv =====
`timescale 1ns / 1ps
// Channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_stall   | command, point, kind, player, shift
// out     | out       | out_valid/out_stall | status, resolved, flags, tile_count
// Place, resolve and probe read one stored tile per cycle.
// Remove scans, then moves each later tile down one entry, reading the next
// entry while writing the previous one.
// Reset clears the count, the landed flag and the handshake state; memory is
// left as is. A stalled result holds in the output register; no new item is
// taken until it leaves.
`include "assert_macros.svh"
module tile_table_aabb_collision_top
	import ttac_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [0:0]               cfg_index,
	input  logic [15:0]              cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               command,
	input  logic signed [23:0]       point_x,
	input  logic signed [23:0]       point_y,
	input  logic [1:0]               tile_kind,
	input  logic signed [23:0]       player_x,
	input  logic signed [23:0]       player_y,
	input  logic signed [16:0]       shift_x,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [2:0]               status,
	output logic signed [23:0]       resolved_x,
	output logic signed [23:0]       resolved_y,
	output logic                     landed,
	output logic                     wall_hit,
	output logic [7:0]               tile_count
);
	// Tile memory: x, y and kind packed in one word, one write and one read port.
	localparam int MemW = 2 * CoordW + 2;
	logic [MemW-1:0] mem [TableDepth];
	logic [MemW-1:0] rd_data;
	logic [IdxW-1:0] rd_addr;
	logic [IdxW-1:0] wr_addr;
	logic [MemW-1:0] wr_data;
	logic            wr_en;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data <= mem[rd_addr];
	end

	state_t state_q, state_nx;
	logic [15:0] width_q, height_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] idx_q;        // address being read
	logic            rdv_q;        // rd_data is valid for entry idx_q-1
	logic [1:0] cmd_q;
	logic signed [CoordW-1:0] px_q, py_q, bx_q, by_q;
	logic signed [16:0] sh_q;
	logic [1:0] kind_q;
	logic landed_q, wall_q;
	status_t st_q;
	logic out_valid_q;

	assign cfg_ready = (state_q == S_IDLE) && !out_valid_q;
	assign in_stall  = (state_q != S_IDLE) || out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 16'd7680;
			height_q <= 16'd7680;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Tile fields of the entry just read.
	logic signed [CoordW-1:0] tx, ty;
	assign tx = rd_data[2*CoordW+1:CoordW+2];
	assign ty = rd_data[CoordW+1:2];

	// Overlap and push arithmetic on the current box.
	logic signed [WideW-1:0] txw, tyw, bxw, byw, sxw, ww, hw, edw;
	logic ovl_res, ovl_prb, pt_in, same_pt;
	logic signed [WideW-1:0] dx, dy, adx, ady, penx, peny;
	logic signed [CoordW-1:0] nbx, nby;
	logic set_land;
	always_comb begin
		txw = WideW'(tx);
		tyw = WideW'(ty);
		bxw = WideW'(bx_q);
		byw = WideW'(by_q);
		sxw = bxw + WideW'(sh_q);
		ww  = WideW'({1'b0, width_q});
		hw  = WideW'({1'b0, height_q});
		edw = WideW'(TileEdge);
		ovl_res = (txw < bxw + ww) && (txw + edw > bxw) && (tyw < byw + hw) && (tyw + edw > byw);
		ovl_prb = (txw < sxw + ww) && (txw + edw > sxw) && (tyw < byw + hw) && (tyw + edw > byw);
		pt_in = (WideW'(px_q) >= txw) && (WideW'(px_q) < txw + edw)
			&& (WideW'(py_q) >= tyw) && (WideW'(py_q) < tyw + edw);
		same_pt = (tx == px_q) && (ty == py_q);
		dx = ((txw <<< 1) + edw) - ((bxw <<< 1) + ww);
		dy = ((tyw <<< 1) + edw) - ((byw <<< 1) + hw);
		adx = dx[WideW-1] ? -dx : dx;
		ady = dy[WideW-1] ? -dy : dy;
		penx = edw + ww - adx;
		peny = edw + hw - ady;
		nbx = bx_q;
		nby = by_q;
		set_land = 1'b0;
		if (penx < peny) begin
			if (dx > 0) nbx = sat24(bxw - (penx >>> 1));
			else nbx = sat24(bxw + (penx >>> 1));
		end else begin
			set_land = dy > 0;
			if (!dy[WideW-1]) nby = sat24(byw - (peny >>> 1));
			else nby = sat24(byw + (peny >>> 1));
		end
	end

	logic in_acc;
	assign in_acc = in_valid && !in_stall;
	logic scan_end;
	assign scan_end = rdv_q && (idx_q == count_q);

	// Next state.
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: if (in_acc) state_nx = S_SCAN;
			S_SCAN: begin
				if (cmd_q == CMD_PLACE && count_q == CntW'(TableDepth)) state_nx = S_DONE;
				else if (count_q == '0) state_nx = S_DONE;
				else if (rdv_q) begin
					if (cmd_q == CMD_REMOVE && pt_in) state_nx = S_SHIFT;
					else if (cmd_q == CMD_PLACE && same_pt) state_nx = S_DONE;
					else if (cmd_q == CMD_PROBE && ovl_prb) state_nx = S_DONE;
					else if (scan_end) state_nx = S_DONE;
				end
			end
			S_SHIFT: if (rdv_q && idx_q == count_q) state_nx = S_DONE;
				else if (idx_q == count_q) state_nx = S_DONE;
			S_DONE: state_nx = S_OUT;
			S_OUT: state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		rd_addr = idx_q[IdxW-1:0];
		wr_en = 1'b0;
		wr_addr = idx_q[IdxW-1:0];
		wr_data = {px_q, py_q, kind_q};
		case (state_q)
			S_SHIFT: begin
				wr_en = rdv_q;
				wr_addr = IdxW'(idx_q - 1'b1 - 1'b1);
				wr_data = rd_data;
			end
			S_DONE: begin
				wr_en = (cmd_q == CMD_PLACE) && (st_q == ST_PLACED);
				wr_addr = count_q[IdxW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rdv_q <= 1'b0;
			landed_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_acc) begin
					idx_q <= '0;
					rdv_q <= 1'b0;
					if (command == CMD_RESOLVE) landed_q <= 1'b0;
				end
				S_SCAN: begin
					// Stop issuing reads past the last entry. On a remove hit
					// the read of the entry after the match is already issued.
					if (idx_q != count_q) begin
						idx_q <= idx_q + 1'b1;
						rdv_q <= 1'b1;
					end else rdv_q <= 1'b0;
					if (rdv_q && cmd_q == CMD_RESOLVE && ovl_res && set_land) landed_q <= 1'b1;
				end
				S_SHIFT: begin
					if (idx_q != count_q) begin
						idx_q <= idx_q + 1'b1;
						rdv_q <= 1'b1;
					end else rdv_q <= 1'b0;
					if (state_nx == S_DONE) count_q <= count_q - 1'b1;
				end
				S_DONE: if (wr_en) count_q <= count_q + 1'b1;
				S_OUT: out_valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	// Payload registers of the item at work.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_acc) begin
				cmd_q <= command;
				px_q <= point_x;
				py_q <= point_y;
				kind_q <= tile_kind;
				bx_q <= player_x;
				by_q <= player_y;
				sh_q <= shift_x;
				wall_q <= 1'b0;
			end
			S_SCAN: if (rdv_q) begin
				if (cmd_q == CMD_RESOLVE && ovl_res) begin
					bx_q <= nbx;
					by_q <= nby;
				end
				if (cmd_q == CMD_PROBE && ovl_prb) wall_q <= 1'b1;
			end
			default: ;
		endcase
		if (state_q == S_SCAN && state_nx == S_DONE) begin
			case (cmd_q)
				CMD_PLACE: st_q <= (count_q == CntW'(TableDepth)) ? ST_FULL
					: ((rdv_q && same_pt) ? ST_OCCUPIED : ST_PLACED);
				CMD_REMOVE: st_q <= ST_NOHIT;
				default: st_q <= ST_DONE;
			endcase
		end
		if (state_q == S_SCAN && state_nx == S_SHIFT) st_q <= ST_REMOVED;
		if (state_q == S_OUT) begin
			status <= st_q;
			resolved_x <= bx_q;
			resolved_y <= by_q;
			landed <= landed_q;
			wall_hit <= wall_q;
			tile_count <= 8'(count_q);
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_IMPLIES(a_count_max, clk, arst_n, 1'b1, count_q <= CntW'(TableDepth))
	`ASSERT_IMPLIES(a_busy_stall, clk, arst_n, state_q != S_IDLE, in_stall)
	`ASSERT_NEXT(a_out_follows, clk, arst_n, state_q == S_OUT, out_valid)
endmodule
